### design/bee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_pkg
// shared constants, types and the log2 segment table of the entropy block
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int NUM_BINS       = 256;
  localparam int BIN_IDX_W      = 8;
  localparam int LOG_FRAC       = 16;
  localparam int MANT_BITS      = 40;
  localparam int SEG_BITS       = 4;
  localparam int REM_BITS       = MANT_BITS - SEG_BITS;
  localparam int TAB_W          = 17;
  localparam int DATA_W         = 8;
  localparam int ENTROPY_W      = 16;
  localparam int BYTE_COUNT_W   = 21;
  localparam int THRESH_W       = 16;

  // tag travelling with a sweep item
  typedef struct packed {
    logic vld;
    logic is_total;
  } sweep_tag_t;

  // log2(1 + i/16), 16 fraction bits
  function automatic logic [TAB_W-1:0] log_tab(input logic [SEG_BITS:0] i);
    logic [TAB_W-1:0] v;
    begin
      case (i)
        5'd0:    v = 17'd0;
        5'd1:    v = 17'd5732;
        5'd2:    v = 17'd11136;
        5'd3:    v = 17'd16248;
        5'd4:    v = 17'd21098;
        5'd5:    v = 17'd25711;
        5'd6:    v = 17'd30109;
        5'd7:    v = 17'd34312;
        5'd8:    v = 17'd38336;
        5'd9:    v = 17'd42196;
        5'd10:   v = 17'd45904;
        5'd11:   v = 17'd49472;
        5'd12:   v = 17'd52911;
        5'd13:   v = 17'd56229;
        5'd14:   v = 17'd59434;
        5'd15:   v = 17'd62534;
        5'd16:   v = 17'd65536;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

### design/byte_entropy_estimator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_entropy_estimator_core
// shannon entropy of a byte set from a 256 bin histogram in block memory
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while a set streams in, input stalled from the
//   last byte until the result is loaded into the output register
// after the last byte: a drain state, a sweep issuing each of the 256 bins and then
//   the total, the log/multiply pipe, one divider step per dividend bit plus a done
//   flag, and the output register load
// reset: synchronous, clears all histogram valid bits, totals and flags at once,
//   threshold returns to 7.0
module byte_entropy_estimator_core #(
  parameter int COUNT_BITS = bee_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = bee_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // byte requests
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bee_pkg::DATA_W-1:0]      data_byte,
  input  wire logic                            last_byte,
  // result requests
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bee_pkg::ENTROPY_W-1:0]        entropy_q,
  output logic                                 suspicious,
  output logic [bee_pkg::BYTE_COUNT_W-1:0]     byte_count,
  output logic                                 overflow,
  // threshold write requests
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bee_pkg::THRESH_W-1:0]    suspicious_threshold
);
  import bee_pkg::*;

  localparam int XW   = COUNT_BITS + 1;                 // counts reach 2^COUNT_BITS
  localparam int LW   = LOG_FRAC + $clog2(XW + 1);      // log2 result width
  localparam int PW   = XW + LW;                        // f * log2 f
  localparam int DW   = PW + FRAC_BITS + 1;             // divider dividend
  localparam int WW   = DW - LOG_FRAC;                  // doubled entropy
  localparam logic [XW-1:0] LIMIT = {1'b1, {COUNT_BITS{1'b0}}};
  localparam logic [THRESH_W-1:0] THRESH_RST =
    ((7 << FRAC_BITS) > 65535) ? 16'hFFFF : THRESH_W'(7 << FRAC_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;
  logic [THRESH_W-1:0] thresh;

  // histogram memory, entries valid once written since the last clear
  logic [XW-1:0]        hist_mem [NUM_BINS];
  logic [XW-1:0]        hist_rd;
  logic [NUM_BINS-1:0]  bin_vld;
  logic [BIN_IDX_W-1:0] rd_addr;
  logic                 mem_we;
  logic [XW-1:0]        cur_cnt, new_cnt;

  // increment pipe
  logic                 a_v;
  logic [BIN_IDX_W-1:0] a_addr;
  logic                 lw_v;
  logic [BIN_IDX_W-1:0] lw_addr;
  logic [XW-1:0]        lw_data;

  logic [XW-1:0] total;
  logic          ovf;
  logic [XW-1:0] res_n;
  logic          res_ovf;

  // sweep
  logic [BIN_IDX_W:0] cnt;
  sweep_tag_t         iss_tag, p0_tag, lg_tag, p4_tag;
  logic               p0_vld;
  logic [XW-1:0]      f_in, lg_x;
  logic [LW-1:0]      lg_val;
  logic [PW-1:0]      p4_prod;
  logic [PW-1:0]      sum;

  logic          div_start, div_done;
  logic [DW-1:0] dividend, quotient;
  logic [WW-1:0] w_val;
  logic [WW-1:0] h_val;
  logic [ENTROPY_W-1:0] h_sat;

  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // read address: incoming byte while streaming, bin counter while sweeping
  assign rd_addr = (state == ST_IDLE) ? data_byte : cnt[BIN_IDX_W-1:0];

  // read-modify-write, forward the write that landed with this read
  always_comb begin
    if (lw_v && lw_addr == a_addr)  cur_cnt = lw_data;
    else if (bin_vld[a_addr])       cur_cnt = hist_rd;
    else                            cur_cnt = '0;
    new_cnt = cur_cnt + 1'b1;
    mem_we  = a_v;
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[a_addr] <= new_cnt;
    hist_rd <= hist_mem[rd_addr];
  end

  // sweep item issue
  always_comb begin
    iss_tag.vld      = (state == ST_SWEEP);
    iss_tag.is_total = cnt[BIN_IDX_W];
    if (p0_tag.is_total) f_in = res_n;
    else if (p0_vld)     f_in = hist_rd;
    else                 f_in = '0;
  end

  bee_log2 #(.XW(XW)) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (p0_tag),
    .x       (f_in),
    .out_tag (lg_tag),
    .out_x   (lg_x),
    .log_val (lg_val)
  );

  // n * log2(n) arrives from the multiplier in the start cycle, bin sum is complete
  assign dividend  = DW'(p4_prod - sum) << (FRAC_BITS + 1);
  assign div_start = (state == ST_FLUSH) && p4_tag.vld && p4_tag.is_total;

  bee_div #(.DW(DW), .NW(XW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (res_n),
    .done     (div_done),
    .quotient (quotient)
  );

  // round half up, saturate
  always_comb begin
    w_val = quotient[DW-1:LOG_FRAC];
    h_val = (w_val + 1'b1) >> 1;
    if (h_val > WW'(16'hFFFF)) h_sat = 16'hFFFF;
    else                       h_sat = h_val[ENTROPY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      thresh    <= THRESH_RST;
      bin_vld   <= '0;
      a_v       <= 1'b0;
      lw_v      <= 1'b0;
      total     <= '0;
      ovf       <= 1'b0;
      cnt       <= '0;
      p0_tag    <= '0;
      p4_tag    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) thresh <= suspicious_threshold;

      a_v  <= in_acc && (total != LIMIT);
      lw_v <= a_v;
      if (a_v) bin_vld[a_addr] <= 1'b1;

      p0_tag <= iss_tag;
      p4_tag <= lg_tag;

      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (total == LIMIT) begin
              ovf <= 1'b1;
            end else begin
              total <= total + 1'b1;
            end
            if (last_byte) state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last increment writes this cycle
          total <= '0;
          ovf   <= 1'b0;
          cnt   <= '0;
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt[BIN_IDX_W]) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (div_start) begin
            bin_vld <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // payload
    if (in_acc) a_addr <= data_byte;
    lw_addr <= a_addr;
    lw_data <= new_cnt;
    p0_vld  <= bin_vld[cnt[BIN_IDX_W-1:0]];
    p4_prod <= PW'(lg_x * lg_val);
    if (state == ST_DRAIN) begin
      res_n   <= total;
      res_ovf <= ovf;
      sum     <= '0;
    end else if (p4_tag.vld && !p4_tag.is_total) begin
      sum <= sum + p4_prod;
    end
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      entropy_q  <= h_sat;
      suspicious <= (h_sat > thresh);
      byte_count <= BYTE_COUNT_W'(res_n);
      overflow   <= res_ovf;
    end
  end

endmodule
`default_nettype wire

### design/bee_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_log2
// three stage log2: leading one, table plus interpolation, final sum
// ----------------------------------------------------------------------------
module bee_log2 #(
  parameter int XW = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bee_pkg::sweep_tag_t  in_tag,
  input  wire logic [XW-1:0]        x,
  output bee_pkg::sweep_tag_t       out_tag,
  output logic [XW-1:0]             out_x,
  output logic [bee_pkg::LOG_FRAC+$clog2(XW+1)-1:0] log_val
);
  import bee_pkg::*;

  localparam int EW = $clog2(XW);
  localparam int LW = LOG_FRAC + $clog2(XW + 1);
  localparam int PW = TAB_W + REM_BITS;

  sweep_tag_t          tag1, tag2;
  logic [XW-1:0]       x1, x2;
  logic [EW-1:0]       e1, e2;
  logic [EW-1:0]       e_enc;
  logic [XW+MANT_BITS-1:0] shifted;
  logic [MANT_BITS-1:0]    mant;
  logic [SEG_BITS-1:0]     idx;
  logic [TAB_W-1:0]    lo, hi, lo2;
  logic [PW-1:0]       prod2;

  // leading one
  always_comb begin
    e_enc = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) e_enc = EW'(i);
    end
  end

  always_comb begin
    shifted = {{MANT_BITS{1'b0}}, x1} << (7'(MANT_BITS) - 7'(e1));
    mant    = shifted[MANT_BITS-1:0];
    idx     = mant[MANT_BITS-1 -: SEG_BITS];
    lo      = log_tab({1'b0, idx});
    hi      = log_tab({1'b0, idx} + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      out_tag <= '0;
    end else begin
      tag1    <= in_tag;
      tag2    <= tag1;
      out_tag <= tag2;
    end
    x1      <= x;
    e1      <= e_enc;
    x2      <= x1;
    e2      <= e1;
    lo2     <= lo;
    prod2   <= PW'(hi - lo) * PW'(mant[REM_BITS-1:0]);
    out_x   <= x2;
    log_val <= LW'({e2, {LOG_FRAC{1'b0}}}) + LW'(lo2) + LW'(prod2[PW-1:REM_BITS]);
  end

endmodule
`default_nettype wire

### design/bee_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bee_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bee_div #(
  parameter int DW = 55,
  parameter int NW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [NW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   trial;

  assign trial = {rem, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= NW'(trial - {1'b0, dvs});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= trial[NW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire
